/* src/mbsp_pkg.sv */
// Shared types and constants of the MIDI byte stream parser.
package mbsp_pkg;

	// Default number of queued commands between the classifier and the output stage.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Real-time and ignored system bytes.
	localparam logic [7:0] RT_CLOCK    = 8'hF8;
	localparam logic [7:0] RT_START    = 8'hFA;
	localparam logic [7:0] RT_CONTINUE = 8'hFB;
	localparam logic [7:0] RT_STOP     = 8'hFC;
	localparam logic [7:0] RT_IGN_FD   = 8'hFD;
	localparam logic [7:0] RT_IGN_FE   = 8'hFE;
	localparam logic [7:0] RT_IGN_FF   = 8'hFF;

	// Status classes, upper nibble of the running status.
	localparam logic [3:0] CLS_NOTE_OFF = 4'h8;
	localparam logic [3:0] CLS_NOTE_ON  = 4'h9;
	localparam logic [3:0] CLS_POLY     = 4'hA;
	localparam logic [3:0] CLS_CONTROL  = 4'hB;
	localparam logic [3:0] CLS_PROGRAM  = 4'hC;
	localparam logic [3:0] CLS_AFTER    = 4'hD;
	localparam logic [3:0] CLS_BEND     = 4'hE;

	typedef enum logic [3:0] {
		EV_CLOCK    = 4'd0,
		EV_START    = 4'd1,
		EV_CONTINUE = 4'd2,
		EV_STOP     = 4'd3,
		EV_STATUS   = 4'd4,
		EV_FIRST    = 4'd5,
		EV_PROGRAM  = 4'd6,
		EV_AFTER    = 4'd7,
		EV_NOTE_ON  = 4'd8,
		EV_NOTE_OFF = 4'd9,
		EV_POLY     = 4'd10,
		EV_CONTROL  = 4'd11,
		EV_BEND     = 4'd12
	} event_kind_t;

	// One classified byte. When pair is set, a first-data event precedes kind.
	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  status;
		logic [6:0]  first;
		logic [6:0]  second;
		logic        pair;
	} cmd_t;

endpackage

/* src/mbsp_front.sv */
// Classifier: accepts bytes, tracks running status and queues one command per result-giving byte.
module mbsp_front import mbsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [7:0] running_status_q;
	logic       first_held_q;
	logic [6:0] first_byte_q;

	logic       accept;
	logic       emit;
	logic [7:0] rs_d;
	logic       held_d;
	logic [6:0] fb_d;
	logic [6:0] held_val;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign held_val = first_held_q ? first_byte_q : 7'd0;
	assign push     = accept && emit;

	always_comb begin
		emit            = 1'b0;
		rs_d            = running_status_q;
		held_d          = first_held_q;
		fb_d            = first_byte_q;
		push_cmd.kind   = EV_STATUS;
		push_cmd.status = running_status_q;
		push_cmd.first  = held_val;
		push_cmd.second = 7'd0;
		push_cmd.pair   = 1'b0;
		if (s_tdata[7]) begin
			unique case (s_tdata)
				RT_CLOCK: begin
					emit = 1'b1;
					push_cmd.kind = EV_CLOCK;
				end
				RT_START: begin
					emit = 1'b1;
					push_cmd.kind = EV_START;
				end
				RT_CONTINUE: begin
					emit = 1'b1;
					push_cmd.kind = EV_CONTINUE;
				end
				RT_STOP: begin
					emit = 1'b1;
					push_cmd.kind = EV_STOP;
				end
				RT_IGN_FD, RT_IGN_FE, RT_IGN_FF: begin
					emit = 1'b0;
				end
				default: begin
					emit            = 1'b1;
					rs_d            = s_tdata;
					held_d          = 1'b0;
					fb_d            = 7'd0;
					push_cmd.kind   = EV_STATUS;
					push_cmd.status = s_tdata;
					push_cmd.first  = 7'd0;
				end
			endcase
		end else if (running_status_q != 8'd0) begin
			if (!first_held_q) begin
				fb_d           = s_tdata[6:0];
				emit           = 1'b1;
				push_cmd.first = s_tdata[6:0];
				if (running_status_q[7:4] == CLS_PROGRAM) begin
					push_cmd.kind = EV_PROGRAM;
					push_cmd.pair = 1'b1;
				end else if (running_status_q[7:4] == CLS_AFTER) begin
					push_cmd.kind = EV_AFTER;
					push_cmd.pair = 1'b1;
				end else begin
					push_cmd.kind = EV_FIRST;
					held_d        = 1'b1;
				end
			end else begin
				// Second data byte completes a two-byte message.
				held_d          = 1'b0;
				push_cmd.first  = first_byte_q;
				push_cmd.second = s_tdata[6:0];
				unique case (running_status_q[7:4])
					CLS_NOTE_ON: begin
						emit = 1'b1;
						push_cmd.kind = (s_tdata[6:0] != 7'd0) ? EV_NOTE_ON : EV_NOTE_OFF;
					end
					CLS_NOTE_OFF: begin
						emit = 1'b1;
						push_cmd.kind = EV_NOTE_OFF;
					end
					CLS_POLY: begin
						emit = 1'b1;
						push_cmd.kind = EV_POLY;
					end
					CLS_CONTROL: begin
						emit = 1'b1;
						push_cmd.kind = EV_CONTROL;
					end
					CLS_BEND: begin
						emit = 1'b1;
						push_cmd.kind = EV_BEND;
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_status_q <= 8'd0;
			first_held_q     <= 1'b0;
			first_byte_q     <= 7'd0;
		end else if (accept) begin
			running_status_q <= rs_d;
			first_held_q     <= held_d;
			first_byte_q     <= fb_d;
		end
	end

endmodule

/* src/mbsp_queue.sv */
// Short command queue between the classifier and the output stage.
module mbsp_queue import mbsp_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  cmd_t                       push_cmd,
	input  logic                       pop,
	output cmd_t                       pop_cmd,
	output logic                       full,
	output logic                       not_empty,
	output logic [$clog2(Depth+1)-1:0] level
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign level     = count_q;
	assign pop_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + {{(CntW-1){1'b0}}, push} - {{(CntW-1){1'b0}}, pop};
		end
	end

endmodule

/* src/mbsp_back.sv */
// Output stage: expands queued commands into result words and holds them in the output register.
module mbsp_back import mbsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] status_value, [12:8] channel_number,
	                              // [19:13] first_value, [26:20] second_value,
	                              // [31:27] zero
	output logic [3:0]  m_tuser,  // [3:0] event_kind
	output logic        m_tlast   // last_of_run
);

	logic        valid_q;
	logic        pend_q;
	cmd_t        pend_cmd_q;
	event_kind_t kind_q;
	logic [7:0]  status_q;
	logic [6:0]  first_q;
	logic [6:0]  second_q;
	logic        last_q;
	logic        out_free;
	logic [4:0]  channel;

	assign out_free = !valid_q || m_tready;
	assign pop      = out_free && !pend_q && q_valid;
	assign channel  = {1'b0, status_q[3:0]} + 5'd1;

	assign m_tvalid = valid_q;
	assign m_tlast  = last_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {5'd0, second_q, first_q, channel, status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= q_valid;
				pend_q  <= q_valid && q_cmd.pair;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				kind_q   <= pend_cmd_q.kind;
				status_q <= pend_cmd_q.status;
				first_q  <= pend_cmd_q.first;
				second_q <= pend_cmd_q.second;
				last_q   <= 1'b1;
			end else if (q_valid) begin
				// A paired command first shows its first-data word.
				kind_q     <= q_cmd.pair ? EV_FIRST : q_cmd.kind;
				status_q   <= q_cmd.status;
				first_q    <= q_cmd.first;
				second_q   <= q_cmd.second;
				last_q     <= !q_cmd.pair;
				pend_cmd_q <= q_cmd;
			end
		end
	end

endmodule

/* src/midi_byte_stream_parser.sv */
// Top level of the MIDI byte stream parser with running status.
//
// Takes one received MIDI byte per word on the s_ side and gives zero, one or two
// event words on the m_ side. A classifier accepts a byte in every cycle while the
// command queue has room and updates the running status at once; an output stage
// drains the queue and presents one event word per cycle from its output register
// while m_tready is high. An accepted byte is written into the queue, and its first
// event is then loaded into the output register, from which the sink takes it.
// Bytes that give a program change or channel aftertouch give two words in turn
// (first data, then the message), so the sustained rate is one event word per cycle,
// set by the output register; other bytes pass at one per cycle.
module midi_byte_stream_parser import mbsp_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] status_value, [12:8] channel_number,
	                               // [19:13] first_value, [26:20] second_value,
	                               // [31:27] zero
	output logic [3:0]  m_tuser,   // [3:0] event_kind
	output logic        m_tlast    // last_of_run
);

	logic                            push;
	cmd_t                            push_cmd;
	logic                            pop;
	cmd_t                            pop_cmd;
	logic                            q_full;
	logic                            q_valid;
	logic [$clog2(QueueDepth+1)-1:0] q_level;

	mbsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mbsp_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.full      (q_full),
		.not_empty (q_valid),
		.level     (q_level)
	);

	mbsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// The queue never holds more commands than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= ($clog2(QueueDepth+1))'(QueueDepth))
		else $error("command queue overfilled");

	// Only a first-data word can be followed by another word from the same byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == EV_FIRST))
		else $error("non-final word of a run is not first data");

	// Once the first half of a pair is taken, its program or aftertouch word follows.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && m_tlast && (m_tuser == EV_PROGRAM || m_tuser == EV_AFTER)))
		else $error("second word of a pair missing");

endmodule
